FILE: rtl/i2cs_pkg.sv
package i2cs_pkg;

  localparam int unsigned COUNT_WIDTH = 16;

  localparam logic [COUNT_WIDTH-1:0] CountOne = COUNT_WIDTH'(1);

  localparam logic [7:0] StatusMask   = 8'hf8;
  localparam logic [7:0] StStart      = 8'h08;
  localparam logic [7:0] StRepStart   = 8'h10;
  localparam logic [7:0] StSlaWAck    = 8'h18;
  localparam logic [7:0] StSlaWNak    = 8'h20;
  localparam logic [7:0] StDataTxAck  = 8'h28;
  localparam logic [7:0] StDataTxNak  = 8'h30;
  localparam logic [7:0] StSlaRAck    = 8'h40;
  localparam logic [7:0] StSlaRNak    = 8'h48;
  localparam logic [7:0] StDataRxAck  = 8'h50;
  localparam logic [7:0] StDataRxNack = 8'h58;
  localparam logic [7:0] AddrWrMask   = 8'hfe;
  localparam logic [7:0] AddrRdFlag   = 8'h01;

  typedef enum logic {
    CMD_BEGIN = 1'b0,
    CMD_DONE  = 1'b1
  } command_e;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_START   = 3'd1,
    ACT_SEND    = 3'd2,
    ACT_RX_ACK  = 3'd3,
    ACT_RX_NACK = 3'd4,
    ACT_STOP    = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    OUT_OK    = 2'd0,
    OUT_NAK   = 2'd1,
    OUT_UNEXP = 2'd2
  } outcome_e;

  typedef struct packed {
    logic        command;
    logic [7:0]  device_address;
    logic [15:0] write_count;
    logic [15:0] read_count;
    logic [7:0]  bus_status;
    logic [7:0]  bus_data;
    logic [7:0]  next_write_byte;
  } item_t;

  typedef struct packed {
    action_e    action;
    logic [7:0] transmit_byte;
    logic       received_valid;
    logic [7:0] received_byte;
    logic       finished;
    outcome_e   outcome;
    logic [7:0] failing_status;
  } result_t;

endpackage

FILE: rtl/i2cs_if.sv
interface i2cs_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [7:0]  device_address;
  logic [15:0] write_count;
  logic [15:0] read_count;
  logic [7:0]  bus_status;
  logic [7:0]  bus_data;
  logic [7:0]  next_write_byte;

  modport source (
    output valid, command, device_address, write_count, read_count,
           bus_status, bus_data, next_write_byte,
    input  ready
  );
  modport sink (
    input  valid, command, device_address, write_count, read_count,
           bus_status, bus_data, next_write_byte,
    output ready
  );
endinterface

interface i2cs_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] transmit_byte;
  logic       received_valid;
  logic [7:0] received_byte;
  logic       finished;
  logic [1:0] outcome;
  logic [7:0] failing_status;

  modport source (
    output valid, action, transmit_byte, received_valid, received_byte,
           finished, outcome, failing_status,
    input  ready
  );
  modport sink (
    input  valid, action, transmit_byte, received_valid, received_byte,
           finished, outcome, failing_status,
    output ready
  );
endinterface

FILE: rtl/i2cs_engine.sv
module i2cs_engine
  import i2cs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  item_t   item_i,
  output result_t res_o
);

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_W_START = 3'd1,
    PH_W_ADDR  = 3'd2,
    PH_W_DATA  = 3'd3,
    PH_R_START = 3'd4,
    PH_R_ADDR  = 3'd5,
    PH_R_DATA  = 3'd6,
    PH_R_LAST  = 3'd7
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic [7:0]             addr_q, addr_d;
  logic [COUNT_WIDTH-1:0] wl_q, wl_d;
  logic [COUNT_WIDTH-1:0] rl_q, rl_d;
  logic                   wrote_q, wrote_d;
  result_t                res_q, res_d;

  logic [7:0]             st;
  logic [COUNT_WIDTH-1:0] wc, rc;
  logic [7:0]             ack_code, nak_code, rs_code;

  assign st       = item_i.bus_status & StatusMask;
  assign wc       = item_i.write_count[COUNT_WIDTH-1:0];
  assign rc       = item_i.read_count[COUNT_WIDTH-1:0];
  assign ack_code = (phase_q == PH_W_ADDR) ? StSlaWAck : StDataTxAck;
  assign nak_code = (phase_q == PH_W_ADDR) ? StSlaWNak : StDataTxNak;
  assign rs_code  = wrote_q ? StRepStart : StStart;

  always_comb begin
    phase_d = phase_q;
    addr_d  = addr_q;
    wl_d    = wl_q;
    rl_d    = rl_q;
    wrote_d = wrote_q;
    res_d   = '0;

    if (item_i.command == CMD_BEGIN) begin
      addr_d  = item_i.device_address;
      wl_d    = wc;
      rl_d    = rc;
      wrote_d = (wc != '0);
      if (wc != '0) begin
        res_d.action = ACT_START;
        phase_d      = PH_W_START;
      end else if (rc != '0) begin
        res_d.action = ACT_START;
        phase_d      = PH_R_START;
      end else begin
        res_d.finished = 1'b1;
        phase_d        = PH_IDLE;
      end
    end else begin
      unique case (phase_q)
        PH_IDLE: ;
        PH_W_START, PH_R_START: begin
          if (st != ((phase_q == PH_W_START) ? StStart : rs_code)) begin
            res_d.finished       = 1'b1;
            res_d.outcome        = OUT_UNEXP;
            res_d.failing_status = st;
            phase_d              = PH_IDLE;
          end else if (phase_q == PH_W_START) begin
            res_d.action        = ACT_SEND;
            res_d.transmit_byte = addr_q & AddrWrMask;
            phase_d             = PH_W_ADDR;
          end else begin
            res_d.action        = ACT_SEND;
            res_d.transmit_byte = addr_q | AddrRdFlag;
            phase_d             = PH_R_ADDR;
          end
        end
        PH_W_ADDR, PH_W_DATA: begin
          if (st == ack_code) begin
            if (wl_q != '0) begin
              res_d.action        = ACT_SEND;
              res_d.transmit_byte = item_i.next_write_byte;
              wl_d                = wl_q - CountOne;
              phase_d             = PH_W_DATA;
            end else if (rl_q != '0) begin
              res_d.action = ACT_START;
              phase_d      = PH_R_START;
            end else begin
              res_d.action   = ACT_STOP;
              res_d.finished = 1'b1;
              phase_d        = PH_IDLE;
            end
          end else begin
            res_d.finished       = 1'b1;
            res_d.failing_status = st;
            phase_d              = PH_IDLE;
            if (st == nak_code) begin
              res_d.action  = ACT_STOP;
              res_d.outcome = OUT_NAK;
            end else begin
              res_d.outcome = OUT_UNEXP;
            end
          end
        end
        PH_R_ADDR, PH_R_DATA: begin
          if ((phase_q == PH_R_ADDR && st == StSlaRAck) ||
              (phase_q == PH_R_DATA && st == StDataRxAck)) begin
            if (phase_q == PH_R_DATA) begin
              res_d.received_valid = 1'b1;
              res_d.received_byte  = item_i.bus_data;
            end
            if ((rl_q >> 1) != '0) begin
              res_d.action = ACT_RX_ACK;
              phase_d      = PH_R_DATA;
            end else begin
              res_d.action = ACT_RX_NACK;
              phase_d      = PH_R_LAST;
            end
            if (rl_q != '0) begin
              rl_d = rl_q - CountOne;
            end
          end else begin
            res_d.finished       = 1'b1;
            res_d.failing_status = st;
            phase_d              = PH_IDLE;
            if (phase_q == PH_R_ADDR && st == StSlaRNak) begin
              res_d.action  = ACT_STOP;
              res_d.outcome = OUT_NAK;
            end else begin
              res_d.outcome = OUT_UNEXP;
            end
          end
        end
        PH_R_LAST: begin
          res_d.finished = 1'b1;
          phase_d        = PH_IDLE;
          if (st == StDataRxNack) begin
            res_d.received_valid = 1'b1;
            res_d.received_byte  = item_i.bus_data;
            res_d.action         = ACT_STOP;
          end else begin
            res_d.outcome        = OUT_UNEXP;
            res_d.failing_status = st;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      addr_q  <= '0;
      wl_q    <= '0;
      rl_q    <= '0;
      wrote_q <= 1'b0;
      res_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      addr_q  <= addr_d;
      wl_q    <= wl_d;
      rl_q    <= rl_d;
      wrote_q <= wrote_d;
      res_q   <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

FILE: rtl/i2c_master_write_read_sequencer_top.sv
// Write-then-read I2C transaction sequencer for a byte-level bus engine. Send
// a begin word (command 0) with address and counts, then one completion word
// (command 1) per finished engine action; each word returns exactly one word
// naming the next bus action, any received byte and, on the last word of a
// transaction, the outcome. One word is taken per clock unless rsp_o stalls. A
// request is held in the input register from the edge that takes it; the
// result register behind the next-action logic loads from it once the output
// register is free, so a stall on rsp_o holds the result back.
module i2c_master_write_read_sequencer_top
  import i2cs_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  i2cs_req_if.sink       req_i,
  i2cs_rsp_if.source     rsp_o
);

  logic    in_v_q;
  item_t   in_item_q;
  item_t   item_d;
  logic    out_v_q;
  logic    out_free;
  logic    step;
  result_t res;

  assign item_d = '{
    command:         req_i.command,
    device_address:  req_i.device_address,
    write_count:     req_i.write_count,
    read_count:      req_i.read_count,
    bus_status:      req_i.bus_status,
    bus_data:        req_i.bus_data,
    next_write_byte: req_i.next_write_byte
  };

  assign out_free    = !out_v_q || rsp_o.ready;
  assign step        = in_v_q && out_free;
  assign req_i.ready = !in_v_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        in_v_q <= req_i.valid;
      end
      if (out_free) begin
        out_v_q <= in_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      in_item_q <= item_d;
    end
  end

  i2cs_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_item_q),
    .res_o  (res)
  );

  assign rsp_o.valid          = out_v_q;
  assign rsp_o.action         = res.action;
  assign rsp_o.transmit_byte  = res.transmit_byte;
  assign rsp_o.received_valid = res.received_valid;
  assign rsp_o.received_byte  = res.received_byte;
  assign rsp_o.finished       = res.finished;
  assign rsp_o.outcome        = res.outcome;
  assign rsp_o.failing_status = res.failing_status;

  a_rx_with_read_action : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && res.received_valid |->
      res.action == ACT_RX_ACK || res.action == ACT_RX_NACK || res.action == ACT_STOP)
    else $error("received byte without a read or stop action");

  a_unexp_no_action : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && res.finished && res.outcome == OUT_UNEXP |-> res.action == ACT_NONE)
    else $error("unexpected status must end without a bus action");

  a_open_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !res.finished |-> res.outcome == OUT_OK && res.failing_status == '0)
    else $error("outcome reported on an unfinished word");

  a_send_not_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && res.action == ACT_SEND |-> !res.finished)
    else $error("send action on a finishing word");

endmodule

FILE: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cs_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_W_START = 3'd1,
    PH_W_ADDR  = 3'd2,
    PH_W_DATA  = 3'd3,
    PH_R_START = 3'd4,
    PH_R_ADDR  = 3'd5,
    PH_R_DATA  = 3'd6,
    PH_R_LAST  = 3'd7
  } seq_phase_e;

  typedef struct {
    item_t   word;
    bit      typed;
    result_t want;
  } stim_row_t;

  localparam int unsigned RandomWords = 1350;

  logic clk_i;
  logic rst_ni;

  i2cs_req_if req_if ();
  i2cs_rsp_if rsp_if ();

  i2c_master_write_read_sequencer_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // sequencer shadow state
  seq_phase_e             seq_phase;
  logic [7:0]             held_addr;
  logic [COUNT_WIDTH-1:0] wr_remaining;
  logic [COUNT_WIDTH-1:0] rd_remaining;
  logic                   did_write;

  result_t     pending_actions[$];
  bit          steady;
  int unsigned errors;
  int unsigned checked;
  int unsigned rx_bytes;
  int unsigned ends_ok;
  int unsigned ends_nak;
  int unsigned ends_unexp;

  function automatic item_t mk_word(command_e c, logic [7:0] addr, logic [15:0] wc,
                                    logic [15:0] rc, logic [7:0] st, logic [7:0] data,
                                    logic [7:0] nwb);
    item_t w;
    w.command         = c;
    w.device_address  = addr;
    w.write_count     = wc;
    w.read_count      = rc;
    w.bus_status      = st;
    w.bus_data        = data;
    w.next_write_byte = nwb;
    return w;
  endfunction

  function automatic result_t mk_res(action_e a, logic [7:0] tx, logic rv, logic [7:0] rb,
                                     logic fin, outcome_e o, logic [7:0] fs);
    result_t r;
    r.action         = a;
    r.transmit_byte  = tx;
    r.received_valid = rv;
    r.received_byte  = rb;
    r.finished       = fin;
    r.outcome        = o;
    r.failing_status = fs;
    return r;
  endfunction

  function automatic result_t end_transfer(action_e a, outcome_e o, logic [7:0] st);
    result_t r;
    r = '0;
    r.action         = a;
    r.finished       = 1'b1;
    r.outcome        = o;
    r.failing_status = st;
    seq_phase        = PH_IDLE;
    return r;
  endfunction

  function automatic action_e read_request();
    action_e a;
    if (rd_remaining > CountOne) begin
      a         = ACT_RX_ACK;
      seq_phase = PH_R_DATA;
    end else begin
      a         = ACT_RX_NACK;
      seq_phase = PH_R_LAST;
    end
    if (rd_remaining != 0) rd_remaining = rd_remaining - CountOne;
    return a;
  endfunction

  function automatic result_t next_bus_action(item_t w);
    result_t    r;
    logic [7:0] st;
    logic [7:0] ack;
    logic [7:0] nak;
    r  = '0;
    st = w.bus_status & StatusMask;
    if (w.command == CMD_BEGIN) begin
      held_addr    = w.device_address;
      wr_remaining = w.write_count[COUNT_WIDTH-1:0];
      rd_remaining = w.read_count[COUNT_WIDTH-1:0];
      did_write    = (wr_remaining != 0);
      if (wr_remaining != 0) begin
        r.action  = ACT_START;
        seq_phase = PH_W_START;
      end else if (rd_remaining != 0) begin
        r.action  = ACT_START;
        seq_phase = PH_R_START;
      end else begin
        r = end_transfer(ACT_NONE, OUT_OK, 8'h00);
      end
      return r;
    end
    case (seq_phase)
      PH_W_START: begin
        if (st != StStart) begin
          r = end_transfer(ACT_NONE, OUT_UNEXP, st);
        end else begin
          r.action        = ACT_SEND;
          r.transmit_byte = held_addr & AddrWrMask;
          seq_phase       = PH_W_ADDR;
        end
      end
      PH_W_ADDR, PH_W_DATA: begin
        ack = (seq_phase == PH_W_ADDR) ? StSlaWAck : StDataTxAck;
        nak = (seq_phase == PH_W_ADDR) ? StSlaWNak : StDataTxNak;
        if (st == ack) begin
          if (wr_remaining != 0) begin
            r.action        = ACT_SEND;
            r.transmit_byte = w.next_write_byte;
            wr_remaining    = wr_remaining - CountOne;
            seq_phase       = PH_W_DATA;
          end else if (rd_remaining != 0) begin
            r.action  = ACT_START;
            seq_phase = PH_R_START;
          end else begin
            r = end_transfer(ACT_STOP, OUT_OK, 8'h00);
          end
        end else if (st == nak) begin
          r = end_transfer(ACT_STOP, OUT_NAK, st);
        end else begin
          r = end_transfer(ACT_NONE, OUT_UNEXP, st);
        end
      end
      PH_R_START: begin
        if (st != (did_write ? StRepStart : StStart)) begin
          r = end_transfer(ACT_NONE, OUT_UNEXP, st);
        end else begin
          r.action        = ACT_SEND;
          r.transmit_byte = held_addr | AddrRdFlag;
          seq_phase       = PH_R_ADDR;
        end
      end
      PH_R_ADDR: begin
        if (st == StSlaRAck) r.action = read_request();
        else if (st == StSlaRNak) r = end_transfer(ACT_STOP, OUT_NAK, st);
        else r = end_transfer(ACT_NONE, OUT_UNEXP, st);
      end
      PH_R_DATA: begin
        if (st == StDataRxAck) begin
          r.received_valid = 1'b1;
          r.received_byte  = w.bus_data;
          r.action         = read_request();
        end else begin
          r = end_transfer(ACT_NONE, OUT_UNEXP, st);
        end
      end
      PH_R_LAST: begin
        if (st == StDataRxNack) begin
          r                = end_transfer(ACT_STOP, OUT_OK, 8'h00);
          r.received_valid = 1'b1;
          r.received_byte  = w.bus_data;
        end else begin
          r = end_transfer(ACT_NONE, OUT_UNEXP, st);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] pick_count();
    if ($urandom_range(0, 39) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 4));
  endfunction

  // mostly the status the engine should report next; some NAKs, wrong codes and restarts
  function automatic item_t random_word();
    item_t       w;
    int unsigned roll;
    logic [7:0]  good;
    bit          restart;
    w    = mk_word(CMD_DONE, 8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                   8'($urandom), 8'($urandom));
    roll = $urandom_range(0, 99);
    restart = (seq_phase == PH_IDLE) ? (roll < 92) : (roll < 3);
    if (restart) begin
      w.command     = CMD_BEGIN;
      w.write_count = pick_count();
      w.read_count  = pick_count();
    end else if (seq_phase != PH_IDLE && roll >= 8) begin
      case (seq_phase)
        PH_W_START: good = StStart;
        PH_W_ADDR:  good = (roll < 14) ? StSlaWNak : StSlaWAck;
        PH_W_DATA:  good = (roll < 14) ? StDataTxNak : StDataTxAck;
        PH_R_START: good = ((did_write != 0) ^ (roll < 12)) ? StRepStart : StStart;
        PH_R_ADDR:  good = (roll < 14) ? StSlaRNak : StSlaRAck;
        PH_R_DATA:  good = (roll < 11) ? StDataRxNack : StDataRxAck;
        PH_R_LAST:  good = (roll < 11) ? StDataRxAck : StDataRxNack;
        default:    good = 8'($urandom);
      endcase
      w.bus_status = good | 8'($urandom_range(0, 7));
    end
    return w;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 70) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_word(item_t w, int unsigned gap, bit drain);
    if (drain) gap = gap + 2;
    if (gap != 0) req_if.valid <= 1'b0;
    if (drain) begin
      while (pending_actions.size() != 0) @(posedge clk_i);
    end
    repeat (gap) @(posedge clk_i);
    req_if.command         <= w.command;
    req_if.device_address  <= w.device_address;
    req_if.write_count     <= w.write_count;
    req_if.read_count      <= w.read_count;
    req_if.bus_status      <= w.bus_status;
    req_if.bus_data        <= w.bus_data;
    req_if.next_write_byte <= w.next_write_byte;
    req_if.valid           <= 1'b1;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  function automatic void flag_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

  // response side: ready in runs, mostly short stalls, a few long ones
  initial begin
    int unsigned run;
    int unsigned stall;
    rsp_if.ready <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      run   = $urandom_range(1, 12);
      stall = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      rsp_if.ready <= 1'b1;
      repeat (run) @(posedge clk_i);
      if (!steady) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_actions.size() == 0) begin
        $display("%0t ns: result word with no request outstanding, action %0h",
                 $time, rsp_if.action);
        errors++;
      end else begin
        want = pending_actions.pop_front();
        checked++;
        flag_field("action", 8'(want.action), 8'(rsp_if.action));
        flag_field("transmit_byte", want.transmit_byte, rsp_if.transmit_byte);
        flag_field("received_valid", 8'(want.received_valid), 8'(rsp_if.received_valid));
        flag_field("received_byte", want.received_byte, rsp_if.received_byte);
        flag_field("finished", 8'(want.finished), 8'(rsp_if.finished));
        flag_field("outcome", 8'(want.outcome), 8'(rsp_if.outcome));
        flag_field("failing_status", want.failing_status, rsp_if.failing_status);
        if (want.received_valid) rx_bytes++;
        if (want.finished) begin
          case (want.outcome)
            OUT_OK:  ends_ok++;
            OUT_NAK: ends_nak++;
            default: ends_unexp++;
          endcase
        end
      end
    end
  end

  initial begin
    stim_row_t   stim_table[$];
    item_t       w;
    result_t     predicted;
    int unsigned n;
    int unsigned begins;

    errors     = 0;
    checked    = 0;
    rx_bytes   = 0;
    ends_ok    = 0;
    ends_nak   = 0;
    ends_unexp = 0;
    begins     = 0;
    steady     = 1'b0;
    seq_phase    = PH_IDLE;
    held_addr    = '0;
    wr_remaining = '0;
    rd_remaining = '0;
    did_write    = 1'b0;

    rst_ni <= 1'b0;
    req_if.valid           <= 1'b0;
    req_if.command         <= CMD_BEGIN;
    req_if.device_address  <= '0;
    req_if.write_count     <= '0;
    req_if.read_count      <= '0;
    req_if.bus_status      <= '0;
    req_if.bus_data        <= '0;
    req_if.next_write_byte <= '0;

    // completion while idle, empty transfer
    stim_table.push_back('{mk_word(CMD_DONE, 8'h00, 16'h0000, 16'h0000, 8'h08, 8'h00, 8'h00),
      1'b1, mk_res(ACT_NONE, 8'h00, 1'b0, 8'h00, 1'b0, OUT_OK, 8'h00)});
    stim_table.push_back('{mk_word(CMD_BEGIN, 8'h00, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00),
      1'b1, mk_res(ACT_NONE, 8'h00, 1'b0, 8'h00, 1'b1, OUT_OK, 8'h00)});
    // full write then read, status low bits set
    stim_table.push_back('{mk_word(CMD_BEGIN, 8'hff, 16'h0001, 16'h0002, 8'h00, 8'h00, 8'h00),
      1'b1, mk_res(ACT_START, 8'h00, 1'b0, 8'h00, 1'b0, OUT_OK, 8'h00)});
    stim_table.push_back('{mk_word(CMD_DONE, 8'h00, 16'h0, 16'h0, 8'h0f, 8'h00, 8'h00), 1'b0, '0});
    stim_table.push_back('{mk_word(CMD_DONE, 8'h00, 16'h0, 16'h0, 8'h1b, 8'h00, 8'ha5), 1'b0, '0});
    stim_table.push_back('{mk_word(CMD_DONE, 8'h00, 16'h0, 16'h0, 8'h28, 8'h00, 8'h00), 1'b0, '0});
    stim_table.push_back('{mk_word(CMD_DONE, 8'h00, 16'h0, 16'h0, 8'h10, 8'h00, 8'h00), 1'b0, '0});
    stim_table.push_back('{mk_word(CMD_DONE, 8'h00, 16'h0, 16'h0, 8'h40, 8'h00, 8'h00), 1'b0, '0});
    stim_table.push_back('{mk_word(CMD_DONE, 8'h00, 16'h0, 16'h0, 8'h50, 8'h5a, 8'h00), 1'b0, '0});
    stim_table.push_back('{mk_word(CMD_DONE, 8'h00, 16'h0, 16'h0, 8'h58, 8'hff, 8'h00), 1'b0, '0});
    // read only, SLA+R NAK
    stim_table.push_back('{mk_word(CMD_BEGIN, 8'h00, 16'h0000, 16'h0001, 8'h00, 8'h00, 8'h00),
      1'b0, '0});
    stim_table.push_back('{mk_word(CMD_DONE, 8'h00, 16'h0, 16'h0, 8'h08, 8'h00, 8'h00), 1'b0, '0});
    stim_table.push_back('{mk_word(CMD_DONE, 8'h00, 16'h0, 16'h0, 8'h48, 8'h00, 8'h00),
      1'b1, mk_res(ACT_STOP, 8'h00, 1'b0, 8'h00, 1'b1, OUT_NAK, StSlaRNak)});
    // max counts, then begin while busy
    stim_table.push_back('{mk_word(CMD_BEGIN, 8'h81, 16'hffff, 16'hffff, 8'h00, 8'h00, 8'h00),
      1'b1, mk_res(ACT_START, 8'h00, 1'b0, 8'h00, 1'b0, OUT_OK, 8'h00)});
    stim_table.push_back('{mk_word(CMD_DONE, 8'h00, 16'h0, 16'h0, 8'h08, 8'h00, 8'h00), 1'b0, '0});
    stim_table.push_back('{mk_word(CMD_BEGIN, 8'h7e, 16'h0002, 16'h0000, 8'h00, 8'h00, 8'h00),
      1'b1, mk_res(ACT_START, 8'h00, 1'b0, 8'h00, 1'b0, OUT_OK, 8'h00)});
    stim_table.push_back('{mk_word(CMD_DONE, 8'h00, 16'h0, 16'h0, 8'h08, 8'h00, 8'h00), 1'b0, '0});
    stim_table.push_back('{mk_word(CMD_DONE, 8'h00, 16'h0, 16'h0, 8'h20, 8'h00, 8'h00),
      1'b1, mk_res(ACT_STOP, 8'h00, 1'b0, 8'h00, 1'b1, OUT_NAK, StSlaWNak)});
    // data NAK on write
    stim_table.push_back('{mk_word(CMD_BEGIN, 8'h3c, 16'h0002, 16'h0000, 8'h00, 8'h00, 8'h00),
      1'b0, '0});
    stim_table.push_back('{mk_word(CMD_DONE, 8'h00, 16'h0, 16'h0, 8'h08, 8'h00, 8'h00), 1'b0, '0});
    stim_table.push_back('{mk_word(CMD_DONE, 8'h00, 16'h0, 16'h0, 8'h18, 8'h00, 8'h00), 1'b0, '0});
    stim_table.push_back('{mk_word(CMD_DONE, 8'h00, 16'h0, 16'h0, 8'h30, 8'h00, 8'h00),
      1'b1, mk_res(ACT_STOP, 8'h00, 1'b0, 8'h00, 1'b1, OUT_NAK, StDataTxNak)});
    // bad status during a receive
    stim_table.push_back('{mk_word(CMD_BEGIN, 8'h55, 16'h0000, 16'h0003, 8'h00, 8'h00, 8'h00),
      1'b0, '0});
    stim_table.push_back('{mk_word(CMD_DONE, 8'h00, 16'h0, 16'h0, 8'h08, 8'h00, 8'h00), 1'b0, '0});
    stim_table.push_back('{mk_word(CMD_DONE, 8'h00, 16'h0, 16'h0, 8'h40, 8'h00, 8'h00), 1'b0, '0});
    stim_table.push_back('{mk_word(CMD_DONE, 8'h00, 16'h0, 16'h0, 8'hff, 8'h00, 8'h00),
      1'b1, mk_res(ACT_NONE, 8'h00, 1'b0, 8'h00, 1'b1, OUT_UNEXP, 8'hf8)});

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_table[i]) begin
      send_word(stim_table[i].word, gap_len(), 1'b0);
      predicted = next_bus_action(stim_table[i].word);
      pending_actions.push_back(stim_table[i].typed ? stim_table[i].want : predicted);
      if (stim_table[i].word.command == CMD_BEGIN) begins++;
    end

    for (n = 0; n < RandomWords; n++) begin
      if (n % 150 == 0) steady = ($urandom_range(0, 3) == 0);
      w = random_word();
      send_word(w, gap_len(), (n % 400 == 0));
      pending_actions.push_back(next_bus_action(w));
      if (w.command == CMD_BEGIN) begins++;
    end
    req_if.valid <= 1'b0;
    steady       = 1'b0;

    while (pending_actions.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Checked %0d result words from %0d transfers, %0d bytes read back.",
             checked, begins, rx_bytes);
    $display("Endings: %0d clean, %0d on NAK with stop, %0d on bad status.",
             ends_ok, ends_nak, ends_unexp);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
